@@ rtl/mrtb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrtb_pkg - shared types and constants of the multi-resource token bucket
// Payload structs, register indexes, sequencer states and divider request.
// ----------------------------------------------------------------------------
package mrtb_pkg;

	// Number of real buckets and how many of them take part.
	localparam int REAL_BUCKETS   = 4;
	localparam int NUM_BUCKETS    = 4;
	localparam int ACTIVE_BUCKETS = (NUM_BUCKETS < REAL_BUCKETS) ? NUM_BUCKETS : REAL_BUCKETS;
	localparam int BIDX_W         = $clog2(REAL_BUCKETS);

	// Left shift applied to each usage amount.
	localparam int AMP_SHIFT = 32;

	localparam int LIMIT_W = 32;
	localparam int BURST_W = 48;
	localparam int WORD_W  = 64;
	localparam int USAGE_W = 32;
	localparam int COUNT_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = BURST_W;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CYCLES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PACKETS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BITS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_CYCLES  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_PACKETS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_BITS    = 3'd7;

	// Restoring divider: one quotient bit per cycle.
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [15:0]       used_count;
		logic [31:0]       used_cycles;
		logic [15:0]       used_packets;
		logic [31:0]       used_bits;
		logic [WORD_W-1:0] now_time;
	} in_t;

	typedef struct packed {
		logic               throttled;
		logic [WORD_W-1:0]  resume_time;
		logic [COUNT_W-1:0] throttle_total;
	} out_t;

	typedef struct packed {
		logic               start;
		logic [WORD_W-1:0]  dividend;
		logic [LIMIT_W-1:0] divisor;
	} div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL,
		ST_MUL_LO,
		ST_ADD_LO,
		ST_ADD_HI,
		ST_CMP,
		ST_CLAMP,
		ST_DIV,
		ST_MAX,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/mrtb_div.sv @@
// ----------------------------------------------------------------------------
// mrtb_div - 64 by 32 bit unsigned divider
// Restoring division, one quotient bit per cycle; done pulses once at the end.
// ----------------------------------------------------------------------------
module mrtb_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mrtb_pkg::div_req_t req,
	output logic               done,
	output logic [63:0]        quotient
);
	import mrtb_pkg::*;

	logic [LIMIT_W-1:0]   rem_q;
	logic [WORD_W-1:0]    quo_q;
	logic [LIMIT_W-1:0]   divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [LIMIT_W:0]     shifted;
	logic [LIMIT_W:0]     trial;
	logic                 fits;

	// Bring down the next dividend bit and try to subtract.
	always_comb begin
		shifted = {rem_q, quo_q[WORD_W-1]};
		trial   = shifted - {1'b0, divisor_q};
		fits    = (shifted >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_W-2:0], fits};
			rem_q <= fits ? trial[LIMIT_W-1:0] : shifted[LIMIT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/multi_resource_token_bucket.sv @@
// ----------------------------------------------------------------------------
// multi_resource_token_bucket - rate limiter for one traffic class
// Four token buckets (invocations, cycles, packets, bits) checked per event.
//
// Each input transfer is one accounting event and yields exactly one result
// transfer. The buckets are visited one after another by a small sequencer
// that shares a single 32x32 multiplier for the refill and a single
// bit-serial divider for the wait time. The block takes one event at a time:
// a bucket with a zero limit is skipped, otherwise its refill is multiplied,
// added and compared, then a bucket with enough tokens is clamped to its
// burst and one that falls short runs the divider for its wait. A finished
// result sits in an output register, so the next event is taken while that
// result still waits. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module multi_resource_token_bucket (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mrtb_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mrtb_pkg::out_t                    out_data,
	input  logic                              cfg_wen,
	input  logic [mrtb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mrtb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mrtb_pkg::*;

	// Configuration registers.
	logic [LIMIT_W-1:0] limit_q [REAL_BUCKETS];
	logic [BURST_W-1:0] burst_q [REAL_BUCKETS];

	// Architectural state.
	logic [WORD_W-1:0]  tokens_q [REAL_BUCKETS];
	logic [WORD_W-1:0]  last_time_q;
	logic [COUNT_W-1:0] throttle_cnt_q;

	// Per-event working registers.
	state_t             state_q, state_d;
	logic [USAGE_W-1:0] usage_q [REAL_BUCKETS];
	logic [WORD_W-1:0]  now_q;
	logic [WORD_W-1:0]  elapsed_q;
	logic [BIDX_W-1:0]  idx_q;
	logic [WORD_W-1:0]  prod_q;
	logic [WORD_W-1:0]  acc_q;
	logic [WORD_W-1:0]  diff_q;
	logic [WORD_W-1:0]  max_wait_q;
	logic               short_q;

	// Output register.
	logic               out_valid_q;
	out_t               out_q;

	// Sequencer decode.
	logic               accept;
	logic               lim_zero;
	logic               last_bucket;
	logic               is_short;
	logic               advance;
	logic               mul_load;
	logic               mul_hi;
	logic               out_free;
	logic               out_load;

	// Datapath nets.
	logic [LIMIT_W-1:0] lim_cur;
	logic [WORD_W-1:0]  consumed;
	logic [LIMIT_W-1:0] mul_b;
	div_req_t           div_req;
	logic               div_done;
	logic [WORD_W-1:0]  div_quo;

	assign accept      = in_valid && !in_stall;
	assign lim_cur     = limit_q[idx_q];
	assign lim_zero    = (lim_cur == '0);
	assign last_bucket = (idx_q == BIDX_W'(ACTIVE_BUCKETS - 1));
	assign consumed    = WORD_W'({{(WORD_W-USAGE_W){1'b0}}, usage_q[idx_q]} << AMP_SHIFT);
	assign is_short    = (acc_q < consumed);
	assign out_free    = !out_valid_q || !out_stall;
	assign mul_b       = mul_hi ? elapsed_q[WORD_W-1:LIMIT_W] : elapsed_q[LIMIT_W-1:0];

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SEL;
			end
			ST_SEL: begin
				if (!lim_zero)        state_d = ST_MUL_LO;
				else if (last_bucket) state_d = ST_FINISH;
			end
			ST_MUL_LO: state_d = ST_ADD_LO;
			ST_ADD_LO: state_d = ST_ADD_HI;
			ST_ADD_HI: state_d = ST_CMP;
			ST_CMP:    state_d = is_short ? ST_DIV : ST_CLAMP;
			ST_CLAMP:  state_d = last_bucket ? ST_FINISH : ST_SEL;
			ST_DIV: begin
				if (div_done) state_d = ST_MAX;
			end
			ST_MAX:    state_d = last_bucket ? ST_FINISH : ST_SEL;
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_stall = 1'b1;
		advance  = 1'b0;
		mul_load = 1'b0;
		mul_hi   = 1'b0;
		out_load = 1'b0;
		div_req  = '{start: 1'b0, dividend: consumed - acc_q, divisor: lim_cur};
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SEL:    advance  = lim_zero && !last_bucket;
			ST_MUL_LO: mul_load = 1'b1;
			ST_ADD_LO: begin
				mul_load = 1'b1;
				mul_hi   = 1'b1;
			end
			ST_ADD_HI: ;
			ST_CMP:    div_req.start = is_short;
			ST_CLAMP:  advance  = !last_bucket;
			ST_DIV:    ;
			ST_MAX:    advance  = !last_bucket;
			ST_FINISH: out_load = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REAL_BUCKETS; i++) begin
				limit_q[i] <= '0;
				burst_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LIMIT_COUNT:   limit_q[0] <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_CYCLES:  limit_q[1] <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_PACKETS: limit_q[2] <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_BITS:    limit_q[3] <= cfg_data[LIMIT_W-1:0];
				REG_BURST_COUNT:   burst_q[0] <= cfg_data;
				REG_BURST_CYCLES:  burst_q[1] <= cfg_data;
				REG_BURST_PACKETS: burst_q[2] <= cfg_data;
				REG_BURST_BITS:    burst_q[3] <= cfg_data;
				default:           ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Event control state: bucket index, timestamp, tokens, counter
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= '0;
			short_q        <= 1'b0;
			max_wait_q     <= '0;
			last_time_q    <= '0;
			throttle_cnt_q <= '0;
			for (int i = 0; i < REAL_BUCKETS; i++) begin
				tokens_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				// Start a new event: elapsed time wraps at 64 bits.
				idx_q       <= '0;
				short_q     <= 1'b0;
				max_wait_q  <= '0;
				last_time_q <= in_data.now_time;
			end
			if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_CMP && is_short) begin
				short_q <= 1'b1;
			end
			// Bucket met its demand: keep the remainder, capped at the burst.
			if (state_q == ST_CLAMP) begin
				tokens_q[idx_q] <= (diff_q < {{(WORD_W-BURST_W){1'b0}}, burst_q[idx_q]})
					? diff_q : {{(WORD_W-BURST_W){1'b0}}, burst_q[idx_q]};
			end
			// Keep the longest wait over the short buckets.
			if (state_q == ST_MAX && div_quo > max_wait_q) begin
				max_wait_q <= div_quo;
			end
			// Throttled: drain every bucket and count the event, saturating.
			if (out_load && short_q) begin
				for (int i = 0; i < REAL_BUCKETS; i++) begin
					tokens_q[i] <= '0;
				end
				if (throttle_cnt_q != '1) begin
					throttle_cnt_q <= throttle_cnt_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath: usage latch, shared multiplier, refill accumulator
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			usage_q[0] <= USAGE_W'(in_data.used_count);
			usage_q[1] <= in_data.used_cycles;
			usage_q[2] <= USAGE_W'(in_data.used_packets);
			usage_q[3] <= in_data.used_bits;
			now_q      <= in_data.now_time;
			elapsed_q  <= in_data.now_time - last_time_q;
		end
		if (mul_load) begin
			prod_q <= {{(WORD_W-LIMIT_W){1'b0}}, lim_cur} * {{(WORD_W-LIMIT_W){1'b0}}, mul_b};
		end
		// Refill: low partial product, then the high one shifted up 32 bits.
		if (state_q == ST_ADD_LO) begin
			acc_q <= tokens_q[idx_q] + prod_q;
		end
		if (state_q == ST_ADD_HI) begin
			acc_q <= acc_q + {prod_q[WORD_W-LIMIT_W-1:0], {LIMIT_W{1'b0}}};
		end
		if (state_q == ST_CMP) begin
			diff_q <= acc_q - consumed;
		end
	end

	mrtb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// Output register: hold the result until the transfer completes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.throttled   <= short_q;
			out_q.resume_time <= short_q ? (now_q + max_wait_q) : '0;
			if (short_q && throttle_cnt_q != '1) begin
				out_q.throttle_total <= throttle_cnt_q + 1'b1;
			end else begin
				out_q.throttle_total <= throttle_cnt_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ tb/multi_resource_token_bucket_tb.sv @@
// ----------------------------------------------------------------------------
// multi_resource_token_bucket_tb - self-checking bench for the rate limiter
// Sends accounting events through the valid/stall channels under several
// bucket settings. A ledger of the four buckets predicts each verdict, and
// every returned transfer is compared with it field by field.
// ----------------------------------------------------------------------------
module multi_resource_token_bucket_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrtb_pkg::*;

	localparam int NUM_REGS      = 2 * REAL_BUCKETS;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_EVENTS  = 40;
	localparam int QUIET_PHASES  = 2;
	localparam int HOLDOFF       = 8;
	localparam int TAIL_CYCLES   = 400;
	// The slowest event has every bucket short. Add the longest stall on
	// either side and then allow a wide margin.
	localparam int STALL_LIMIT   = 5000;

	typedef logic [CFG_DATA_W-1:0] setting_t [NUM_REGS];

	// Ledger of the buckets: settings, stored tokens, the last timestamp, the
	// throttle count and the verdicts still owed by the block.
	class bucket_ledger;
		logic [LIMIT_W-1:0] rate [REAL_BUCKETS];
		logic [BURST_W-1:0] cap [REAL_BUCKETS];
		logic [WORD_W-1:0]  tokens [REAL_BUCKETS];
		logic [WORD_W-1:0]  last_stamp;
		logic [COUNT_W-1:0] throttle_count;
		out_t               pending_verdicts [$];
		int                 errors;

		function new();
			int b;
			for (b = 0; b < REAL_BUCKETS; b++) begin
				rate[b]   = '0;
				cap[b]    = '0;
				tokens[b] = '0;
			end
			last_stamp     = '0;
			throttle_count = '0;
			errors         = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx <= REG_LIMIT_BITS) begin
				rate[BIDX_W'(idx - REG_LIMIT_COUNT)] = data[LIMIT_W-1:0];
			end else begin
				cap[BIDX_W'(idx - REG_BURST_COUNT)] = data;
			end
		endfunction

		// Charge one event against the buckets and queue the verdict it owes.
		function void account_event(in_t ev);
			logic [WORD_W-1:0] amount [REAL_BUCKETS];
			logic [WORD_W-1:0] span, need, have, shortfall, longest, rest;
			logic              enabled, fell_short;
			out_t              verdict;
			int                b;
			amount[0] = WORD_W'(ev.used_count);
			amount[1] = WORD_W'(ev.used_cycles);
			amount[2] = WORD_W'(ev.used_packets);
			amount[3] = WORD_W'(ev.used_bits);
			enabled = 1'b0;
			for (b = 0; b < ACTIVE_BUCKETS; b++) begin
				if (rate[b] != '0) enabled = 1'b1;
			end
			// Elapsed time wraps when the clock runs backwards.
			span       = ev.now_time - last_stamp;
			last_stamp = ev.now_time;
			longest    = '0;
			fell_short = 1'b0;
			if (enabled) begin
				for (b = 0; b < ACTIVE_BUCKETS; b++) begin
					if (rate[b] != '0) begin
						need = amount[b] << AMP_SHIFT;
						have = tokens[b] + WORD_W'(rate[b]) * span;
						if (have < need) begin
							shortfall  = (need - have) / WORD_W'(rate[b]);
							fell_short = 1'b1;
							if (shortfall > longest) longest = shortfall;
						end else begin
							rest      = have - need;
							tokens[b] = (rest < WORD_W'(cap[b])) ? rest : WORD_W'(cap[b]);
						end
					end
				end
			end
			if (fell_short) begin
				for (b = 0; b < REAL_BUCKETS; b++) tokens[b] = '0;
				if (throttle_count != '1) throttle_count = throttle_count + 1'b1;
				verdict.throttled   = 1'b1;
				verdict.resume_time = ev.now_time + longest;
			end else begin
				verdict.throttled   = 1'b0;
				verdict.resume_time = '0;
			end
			verdict.throttle_total = throttle_count;
			pending_verdicts.push_back(verdict);
		endfunction

		function void check_verdict(out_t got);
			out_t want;
			if (pending_verdicts.size() == 0) begin
				$error("verdict with no event outstanding: throttled %0d resume_time %0h total %0d",
					got.throttled, got.resume_time, got.throttle_total);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.throttled !== want.throttled) begin
					$error("throttled: expected %0d, got %0d", want.throttled, got.throttled);
					errors++;
				end
				if (got.resume_time !== want.resume_time) begin
					$error("resume_time: expected %0h, got %0h",
						want.resume_time, got.resume_time);
					errors++;
				end
				if (got.throttle_total !== want.throttle_total) begin
					$error("throttle_total: expected %0d, got %0d",
						want.throttle_total, got.throttle_total);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_t                   in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bucket_ledger      ledger = new();
	bit                bursty = 1'b0;
	int                stall_left = 0;
	int                idle_cycles = 0;
	logic [WORD_W-1:0] stamp = '0;

	multi_resource_token_bucket uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Result side: check each accepted transfer, then decide the next stall.
	// Stalls come in bursts, which start only while the phase is bursty.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			ledger.check_verdict(out_data);
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (bursty && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: count cycles in which neither channel moves a transfer.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_t event_of(logic [15:0] n_calls, logic [31:0] n_cycles,
			logic [15:0] n_packets, logic [31:0] n_bits, logic [WORD_W-1:0] at);
		in_t ev;
		ev.used_count   = n_calls;
		ev.used_cycles  = n_cycles;
		ev.used_packets = n_packets;
		ev.used_bits    = n_bits;
		ev.now_time     = at;
		return ev;
	endfunction

	// Usage amounts: mostly small so that buckets both pass and fall short,
	// now and then the full range.
	function automatic logic [15:0] narrow_usage();
		case ($urandom_range(0, 12))
			0, 1, 2:                 return '0;
			3, 4, 5, 6, 7, 8, 9:     return 16'($urandom_range(1, 8));
			10, 11:                  return 16'($urandom);
			default:                 return '1;
		endcase
	endfunction

	function automatic logic [31:0] wide_usage();
		case ($urandom_range(0, 12))
			0, 1, 2:                 return '0;
			3, 4, 5, 6, 7, 8, 9:     return 32'($urandom_range(1, 64));
			10, 11:                  return $urandom;
			default:                 return '1;
		endcase
	endfunction

	// Offer one event and hold it until the block takes the transfer. Valid
	// stays high on return so that a following event goes straight out.
	task automatic push_event(input in_t ev);
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= ev;
		do @(posedge clk); while (in_stall !== 1'b0);
		ledger.account_event(ev);
		stamp = ev.now_time;
	endtask

	// Drop valid, wait for every verdict, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.pending_verdicts.size() != 0) @(posedge clk);
		repeat (HOLDOFF) @(posedge clk);
	endtask

	// Write all eight registers back to back once the block is idle.
	task automatic apply_settings(input setting_t setting);
		int r;
		drain();
		for (r = 0; r < NUM_REGS; r++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			cfg_data  <= setting[r];
			@(posedge clk);
			ledger.write_register(CFG_IDX_W'(r), setting[r]);
		end
		cfg_wen <= 1'b0;
	endtask

	initial begin
		setting_t          setting;
		in_t               ev;
		logic [LIMIT_W-1:0] rate;
		logic [BURST_W-1:0] cap;
		int                phase, n, b;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings from reset: no bucket enabled, only the timestamp moves.
		push_event(event_of('0, '0, '0, '0, 64'd0));
		push_event(event_of('1, '1, '1, '1, '1));
		push_event(event_of(16'd1, 32'd1, 16'd1, 32'd1, 64'd5));

		// Fastest rates and widest caps; junk above the rate field is dropped.
		for (b = 0; b < REAL_BUCKETS; b++) begin
			setting[REG_LIMIT_COUNT + b] = '1;
			setting[REG_BURST_COUNT + b] = '1;
		end
		apply_settings(setting);
		push_event(event_of('0, '0, '0, '0, 64'd100));
		push_event(event_of(16'd1, '0, '0, '0, 64'd101));
		push_event(event_of('1, '1, '1, '1, 64'd101));
		// Zero elapsed time on empty buckets: short by one unit.
		push_event(event_of(16'd1, '0, '0, '0, 64'd101));
		push_event(event_of(16'h8000, 32'h8000_0000, 16'h8000, 32'h8000_0000,
			64'hFFFF_FFFF_FFFF_FFF0));
		// Clock running backwards.
		push_event(event_of(16'd1, 32'd1, 16'd1, 32'd1, 64'd3));

		// Slowest rate with no room to store tokens.
		for (b = 0; b < REAL_BUCKETS; b++) begin
			setting[REG_LIMIT_COUNT + b] = 48'd1;
			setting[REG_BURST_COUNT + b] = '0;
		end
		apply_settings(setting);
		push_event(event_of('0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_F000));
		// Resume time wraps past zero.
		push_event(event_of(16'd1, 32'd1, 16'd1, 32'd1, 64'hFFFF_FFFF_FFFF_F00A));
		push_event(event_of('0, '1, '0, '0, 64'hFFFF_FFFF_FFFF_F00B));

		// One bucket at a time: first a pass, then a shortfall of half a unit.
		for (b = 0; b < REAL_BUCKETS; b++) begin
			setting = '{default: '0};
			setting[REG_LIMIT_COUNT + b] = 48'h8000_0000;
			setting[REG_BURST_COUNT + b] = 48'h0100_0000_0000;
			apply_settings(setting);
			push_event(event_of(16'd2, 32'd2, 16'd2, 32'd2, stamp + 64'd8));
			push_event(event_of(16'd3, 32'd3, 16'd3, 32'd3, stamp + 64'd1));
		end

		// Random phases, each under its own settings. The last ones run
		// without any idling on either side.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			bursty = (phase < RANDOM_PHASES - QUIET_PHASES) && (phase % 4 != 3);
			for (b = 0; b < REAL_BUCKETS; b++) begin
				case ($urandom_range(0, 7))
					0, 1:    rate = '0;
					2:       rate = '1;
					3:       rate = LIMIT_W'($urandom_range(1, 1024));
					default: rate = $urandom;
				endcase
				case ($urandom_range(0, 5))
					0:       cap = '0;
					1:       cap = '1;
					2:       cap = {16'($urandom), 32'($urandom)};
					3:       cap = 48'({8'($urandom), 32'($urandom)});
					default: cap = 48'($urandom) << $urandom_range(0, 12);
				endcase
				setting[REG_LIMIT_COUNT + b] = {16'($urandom), rate};
				setting[REG_BURST_COUNT + b] = cap;
			end
			apply_settings(setting);
			for (n = 0; n < PHASE_EVENTS; n++) begin
				// Hold the sender once until every verdict has come back.
				if (phase == 1 && n == PHASE_EVENTS / 2) drain();
				case ($urandom_range(0, 19))
					0:       ev.now_time = {32'($urandom), 32'($urandom)};
					1, 2:    ev.now_time = stamp + WORD_W'($urandom_range(0, 1 << 20));
					default: ev.now_time = stamp + WORD_W'($urandom_range(0, 96));
				endcase
				ev.used_count   = narrow_usage();
				ev.used_cycles  = wide_usage();
				ev.used_packets = narrow_usage();
				ev.used_bits    = wide_usage();
				push_event(ev);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending_verdicts.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mrtb_pkg.sv
rtl/mrtb_div.sv
rtl/multi_resource_token_bucket.sv
tb/multi_resource_token_bucket_tb.sv
